// File: src/dqlm_pkg.sv
`default_nettype none

package dqlm_pkg;

	localparam int unsigned KEY_W  = 64;
	localparam int unsigned TIME_W = 64;
	localparam int unsigned RCODE_W = 4;
	localparam int unsigned QR_POS = 15;

	localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
	localparam logic [7:0]  PROTO_UDP        = 8'd17;
	localparam logic [15:0] DEFAULT_DNS_PORT = 16'd53;
	localparam logic        FUNC_EGRESS      = 1'b0;
	localparam logic        FUNC_INGRESS     = 1'b1;

	typedef struct packed {
		logic        func;
		logic [15:0] ethertype;
		logic [7:0]  ip_protocol;
		logic        headers_valid;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [15:0] transaction_id;
		logic [15:0] dns_flags;
		logic [15:0] answers_in;
		logic [63:0] now_ns;
	} in_item_t;

	typedef struct packed {
		logic [63:0]        event_time;
		logic [63:0]        rtt_ns;
		logic [31:0]        client_addr;
		logic [31:0]        server_addr;
		logic [15:0]        dns_id;
		logic [RCODE_W-1:0] response_code;
		logic [15:0]        an_count;
	} out_item_t;

	typedef struct packed {
		logic              valid;
		logic [KEY_W-1:0]  key;
		logic [TIME_W-1:0] start_time;
	} entry_t;

	typedef struct packed {
		logic             query;
		logic             response;
		logic [KEY_W-1:0] key;
	} pkt_class_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

// File: src/dqlm_classify.sv
`default_nettype none

module dqlm_classify
	import dqlm_pkg::*;
(
	input  wire in_item_t   item,
	input  wire logic [15:0] dns_port,
	output pkt_class_t      cls
);

	logic ipv4_udp;

	always_comb begin
		ipv4_udp = (item.ethertype == ETHERTYPE_IPV4) && (item.ip_protocol == PROTO_UDP)
			&& item.headers_valid;
		cls.query = ipv4_udp && (item.func == FUNC_EGRESS)
			&& (item.dport == dns_port) && !item.dns_flags[QR_POS];
		cls.response = ipv4_udp && (item.func == FUNC_INGRESS)
			&& (item.sport == dns_port) && item.dns_flags[QR_POS];
		// client side of the exchange forms the key
		if (item.func == FUNC_INGRESS) begin
			cls.key = {item.transaction_id, item.dst_ip, item.dport};
		end else begin
			cls.key = {item.transaction_id, item.src_ip, item.sport};
		end
	end

endmodule

`default_nettype wire

// File: src/dqlm_store.sv
`default_nettype none

module dqlm_store
	import dqlm_pkg::*;
#(
	parameter int unsigned ENTRIES = 256,
	localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [IDX_W-1:0] waddr,
	input  wire entry_t           wdata,
	input  wire logic             re,
	input  wire logic [IDX_W-1:0] raddr,
	output entry_t                rdata
);

	entry_t mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: src/dns_query_latency_matcher.sv
`default_nettype none

// DNS query/response latency matcher. Egress queries store their timestamp in a
// TABLE_ENTRIES-deep single-port-read table keyed by (id, client IP, client port);
// ingress responses with the same key produce one result and free the entry.
// Every entry lives in one synchronous memory, so each query or response walks
// the table one entry per cycle, stopping early when the key hits; a matched
// response is then posted once the output register can take it.
// Packets that fail the header/port/QR filter are dropped without a table walk.
// After reset the table is swept clear entry by entry with in_stall held high;
// configuration writes are taken at any time (cfg_ready is always high).

module dns_query_latency_matcher
	import dqlm_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data,

	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire in_item_t    in_data,

	output logic             out_valid,
	input  wire logic        out_stall,
	output out_item_t        out_data
);

	localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
	localparam logic [CNT_W-1:0] NUM_ENT = CNT_W'(TABLE_ENTRIES);

	state_t state_q, state_d;

	logic [15:0]       dns_port_q;
	logic [IDX_W-1:0]  clr_q;
	logic [CNT_W-1:0]  issue_q;
	logic              rd_valid_s1;
	logic [IDX_W-1:0]  rd_idx_s1;
	in_item_t          item_q;
	logic [KEY_W-1:0]  key_q;
	logic              ingress_q;
	logic              free_found_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic [TIME_W-1:0] lat_q;
	logic              out_valid_q;
	out_item_t         out_data_q;

	pkt_class_t        cls;
	logic              in_xfer;
	logic              re;
	logic [IDX_W-1:0]  raddr;
	entry_t            rdata;
	logic              we;
	logic [IDX_W-1:0]  waddr;
	entry_t            wdata;
	logic              hit_now;
	logic              last_now;
	logic              free_now;
	logic              out_free;
	logic              out_load;

	dqlm_classify u_classify (
		.item     (in_data),
		.dns_port (dns_port_q),
		.cls      (cls)
	);

	dqlm_store #(
		.ENTRIES (TABLE_ENTRIES)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign hit_now  = rd_valid_s1 && rdata.valid && (rdata.key == key_q);
	assign last_now = rd_valid_s1 && (rd_idx_s1 == LAST_IDX);
	assign free_now = rd_valid_s1 && !rdata.valid;
	assign out_free = !out_valid_q || !out_stall;
	assign raddr    = issue_q[IDX_W-1:0];
	assign re       = (state_q == ST_SCAN) && (issue_q < NUM_ENT) && !hit_now;

	always_comb begin
		state_d  = state_q;
		we       = 1'b0;
		waddr    = '0;
		wdata    = '0;
		out_load = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				if (clr_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_xfer && (cls.query || cls.response)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (hit_now) begin
					if (ingress_q) begin
						state_d = ST_EMIT;
					end else begin
						we      = 1'b1;
						waddr   = rd_idx_s1;
						wdata   = '{valid: 1'b1, key: key_q, start_time: item_q.now_ns};
						state_d = ST_IDLE;
					end
				end else if (last_now) begin
					state_d = ST_IDLE;
					if (!ingress_q && (free_found_q || free_now)) begin
						we    = 1'b1;
						waddr = free_found_q ? free_idx_q : rd_idx_s1;
						wdata = '{valid: 1'b1, key: key_q, start_time: item_q.now_ns};
					end
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					we       = 1'b1;
					waddr    = hit_idx_q;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dns_port_q   <= DEFAULT_DNS_PORT;
			clr_q        <= '0;
			issue_q      <= '0;
			rd_valid_s1  <= 1'b0;
			free_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				dns_port_q <= cfg_data;
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (in_xfer) begin
				issue_q      <= '0;
				free_found_q <= 1'b0;
			end else begin
				if (re) begin
					issue_q <= issue_q + 1'b1;
				end
				if ((state_q == ST_SCAN) && free_now && !free_found_q) begin
					free_found_q <= 1'b1;
				end
			end
			rd_valid_s1 <= re;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= raddr;
		if (in_xfer) begin
			item_q    <= in_data;
			key_q     <= cls.key;
			ingress_q <= cls.response;
		end
		if ((state_q == ST_SCAN) && free_now && !free_found_q) begin
			free_idx_q <= rd_idx_s1;
		end
		if ((state_q == ST_SCAN) && hit_now) begin
			hit_idx_q <= rd_idx_s1;
			lat_q     <= item_q.now_ns - rdata.start_time;
		end
		if (out_load) begin
			out_data_q.event_time    <= item_q.now_ns;
			out_data_q.rtt_ns        <= lat_q;
			out_data_q.client_addr   <= item_q.dst_ip;
			out_data_q.server_addr   <= item_q.src_ip;
			out_data_q.dns_id        <= item_q.transaction_id;
			out_data_q.response_code <= item_q.dns_flags[RCODE_W-1:0];
			out_data_q.an_count      <= item_q.answers_in;
		end
	end

endmodule

`default_nettype wire
